// File: rtl/slt_pkg.sv
// Shared types, character codes and record codes of the shell line tokenizer.
`default_nettype none

package slt_pkg;

  // Limits of the lexer
  localparam int MAX_TOKENS     = 256;
  localparam int MAX_WORD_BYTES = 2047;
  localparam int RESULTS        = 4;   // most records that one input byte can cause
  localparam int QDEPTH         = 4;   // bundle queue depth between front and back

  localparam int TC_W  = 9;
  localparam int WL_W  = 11;
  localparam int CNT_W = $clog2(RESULTS + 1);
  localparam int SUB_W = $clog2(RESULTS);

  // Record kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_WEND = 2'd1;
  localparam logic [1:0] KIND_OP   = 2'd2;
  localparam logic [1:0] KIND_LINE = 2'd3;

  // Operator codes
  localparam logic [2:0] OP_SEMI   = 3'd0;
  localparam logic [2:0] OP_PIPE   = 3'd1;
  localparam logic [2:0] OP_AMP    = 3'd2;
  localparam logic [2:0] OP_GT     = 3'd3;
  localparam logic [2:0] OP_LT     = 3'd4;
  localparam logic [2:0] OP_OR     = 3'd5;
  localparam logic [2:0] OP_AND    = 3'd6;
  localparam logic [2:0] OP_APPEND = 3'd7;
  localparam logic [2:0] OP_NONE   = 3'd0;

  // Lexer modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_QUOTE = 2'd2;

  // Pending operator characters
  localparam logic [1:0] PC_PIPE = 2'd0;
  localparam logic [1:0] PC_AMP  = 2'd1;
  localparam logic [1:0] PC_GT   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One output record
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] op_code;
    logic [7:0] token_number;
    logic       truncated;
  } rec_t;

  // All records caused by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    rec_t [RESULTS-1:0]     recs;
  } bundle_t;

  function automatic rec_t mk_rec(logic [1:0] kind, logic [7:0] bval, logic [2:0] op,
                                  logic [7:0] tok, logic trunc);
    rec_t r;
    r.kind         = kind;
    r.byte_value   = bval;
    r.op_code      = op;
    r.token_number = tok;
    r.truncated    = trunc;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/slt_front.sv
// Front end: accepts bytes, runs the lexer state and builds one record bundle per byte.
`default_nettype none

module slt_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            line_last,
  input  wire logic            q_full,
  output logic                 push,
  output slt_pkg::bundle_t     bundle
);
  import slt_pkg::*;

  // Lexer state
  logic [1:0]      lex_mode,        mode_next;
  logic            quote_is_double, qd_next;
  logic            pend_valid,      pv_next;
  logic [1:0]      pend_char,       pc_next;
  logic [TC_W-1:0] token_count,     tc_next;
  logic [WL_W-1:0] word_length,     wl_next;
  logic            word_overflow,   ov_next;

  logic [CNT_W-1:0] n_next;
  logic [7:0]       pend_byte;
  logic [2:0]       op_double, op_single;
  logic             consumed, is_ws, is_op, accept;
  bundle_t          bundle_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Lookahead byte and codes of the pending operator
  always_comb begin
    unique case (pend_char)
      PC_PIPE: begin
        pend_byte = CH_PIPE; op_double = OP_OR;     op_single = OP_PIPE;
      end
      PC_AMP: begin
        pend_byte = CH_AMP;  op_double = OP_AND;    op_single = OP_AMP;
      end
      default: begin
        pend_byte = CH_GT;   op_double = OP_APPEND; op_single = OP_GT;
      end
    endcase
  end

  assign is_ws = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);
  assign is_op = (in_byte == CH_SEMI) || (in_byte == CH_PIPE) || (in_byte == CH_AMP) ||
                 (in_byte == CH_GT) || (in_byte == CH_LT);

  // One lexer step: up to four records in order
  always_comb begin
    mode_next   = lex_mode;
    qd_next     = quote_is_double;
    pv_next     = pend_valid;
    pc_next     = pend_char;
    tc_next     = token_count;
    wl_next     = word_length;
    ov_next     = word_overflow;
    n_next      = '0;
    consumed    = 1'b0;
    bundle_next = '0;

    // resolve the pending operator with this byte as lookahead
    if (pend_valid) begin
      pv_next = 1'b0;
      if (in_byte == pend_byte) begin
        bundle_next.recs[n_next[SUB_W-1:0]] =
          mk_rec(KIND_OP, 8'd0, op_double, tc_next[7:0], 1'b0);
        consumed = 1'b1;
      end else begin
        bundle_next.recs[n_next[SUB_W-1:0]] =
          mk_rec(KIND_OP, 8'd0, op_single, tc_next[7:0], 1'b0);
      end
      n_next  = n_next + CNT_W'(1);
      tc_next = tc_next + TC_W'(1);
    end

    // the byte itself, unless the pending operator took it or the token limit is reached
    if (!consumed && tc_next < TC_W'(MAX_TOKENS)) begin
      priority if (mode_next == MODE_QUOTE) begin
        if (in_byte == (quote_is_double ? CH_DQ : CH_SQ)) begin
          mode_next = MODE_WORD;
        end else if (wl_next < WL_W'(MAX_WORD_BYTES)) begin
          bundle_next.recs[n_next[SUB_W-1:0]] =
            mk_rec(KIND_BYTE, in_byte, OP_NONE, tc_next[7:0], 1'b0);
          n_next  = n_next + CNT_W'(1);
          wl_next = wl_next + WL_W'(1);
        end else begin
          ov_next = 1'b1;
        end
      end else if (is_ws || is_op) begin
        // close an open word
        if (mode_next == MODE_WORD) begin
          if (wl_next != '0) begin
            bundle_next.recs[n_next[SUB_W-1:0]] =
              mk_rec(KIND_WEND, 8'd0, OP_NONE, tc_next[7:0], ov_next);
            n_next  = n_next + CNT_W'(1);
            tc_next = tc_next + TC_W'(1);
          end
          wl_next   = '0;
          ov_next   = 1'b0;
          mode_next = MODE_IDLE;
        end
        if (is_op && tc_next < TC_W'(MAX_TOKENS)) begin
          priority if (in_byte == CH_SEMI || in_byte == CH_LT) begin
            bundle_next.recs[n_next[SUB_W-1:0]] =
              mk_rec(KIND_OP, 8'd0, (in_byte == CH_SEMI) ? OP_SEMI : OP_LT,
                     tc_next[7:0], 1'b0);
            n_next  = n_next + CNT_W'(1);
            tc_next = tc_next + TC_W'(1);
          end else begin
            pv_next = 1'b1;
            pc_next = (in_byte == CH_PIPE) ? PC_PIPE :
                      (in_byte == CH_AMP)  ? PC_AMP  : PC_GT;
          end
        end
      end else if (in_byte == CH_DQ || in_byte == CH_SQ) begin
        qd_next   = (in_byte == CH_DQ);
        mode_next = MODE_QUOTE;
      end else begin
        mode_next = MODE_WORD;
        if (wl_next < WL_W'(MAX_WORD_BYTES)) begin
          bundle_next.recs[n_next[SUB_W-1:0]] =
            mk_rec(KIND_BYTE, in_byte, OP_NONE, tc_next[7:0], 1'b0);
          n_next  = n_next + CNT_W'(1);
          wl_next = wl_next + WL_W'(1);
        end else begin
          ov_next = 1'b1;
        end
      end
    end

    // end of line: flush operator, close word, line record, clear state
    if (line_last) begin
      if (pv_next) begin
        bundle_next.recs[n_next[SUB_W-1:0]] =
          mk_rec(KIND_OP, 8'd0, (pc_next == PC_PIPE) ? OP_PIPE :
                                (pc_next == PC_AMP)  ? OP_AMP : OP_GT,
                 tc_next[7:0], 1'b0);
        n_next  = n_next + CNT_W'(1);
        tc_next = tc_next + TC_W'(1);
      end
      if (mode_next != MODE_IDLE && wl_next != '0) begin
        bundle_next.recs[n_next[SUB_W-1:0]] =
          mk_rec(KIND_WEND, 8'd0, OP_NONE, tc_next[7:0], ov_next);
        n_next = n_next + CNT_W'(1);
      end
      bundle_next.recs[n_next[SUB_W-1:0]] = mk_rec(KIND_LINE, 8'd0, OP_NONE, 8'd0, 1'b0);
      n_next    = n_next + CNT_W'(1);
      mode_next = MODE_IDLE;
      qd_next   = 1'b0;
      pv_next   = 1'b0;
      pc_next   = PC_PIPE;
      tc_next   = '0;
      wl_next   = '0;
      ov_next   = 1'b0;
    end
    bundle_next.cnt = n_next;
  end

  assign bundle = bundle_next;
  assign push   = accept && (n_next != '0);

  // State update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode        <= MODE_IDLE;
      quote_is_double <= 1'b0;
      pend_valid      <= 1'b0;
      pend_char       <= PC_PIPE;
      token_count     <= '0;
      word_length     <= '0;
      word_overflow   <= 1'b0;
    end else if (accept) begin
      lex_mode        <= mode_next;
      quote_is_double <= qd_next;
      pend_valid      <= pv_next;
      pend_char       <= pc_next;
      token_count     <= tc_next;
      word_length     <= wl_next;
      word_overflow   <= ov_next;
    end
  end

  // A bundle never holds more records than the queue entry can carry
  a_bundle_size: assert property (@(posedge clk) disable iff (rst)
    push |-> (bundle.cnt <= CNT_W'(RESULTS)))
    else $error("front bundle too large");

  // A pending operator only waits between tokens
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (lex_mode == MODE_IDLE))
    else $error("pending operator inside a word");

  // Line end returns the lexer to its reset state
  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && line_last) |=> (token_count == '0 && lex_mode == MODE_IDLE && !pend_valid))
    else $error("state not cleared at line end");

endmodule

`default_nettype wire

// File: rtl/slt_queue.sv
// Short bundle queue that decouples the lexer front end from the record serializer.
`default_nettype none

module slt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire slt_pkg::bundle_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output slt_pkg::bundle_t      head
);
  import slt_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  bundle_t          entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;

  assign full      = (count == (QAW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/slt_back.sv
// Back end: sends the head bundle's records, one per cycle unless stalled, via an output register.
`default_nettype none

module slt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_not_empty,
  input  wire slt_pkg::bundle_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output slt_pkg::rec_t         out_rec,
  output logic                  out_last
);
  import slt_pkg::*;

  logic [SUB_W-1:0] sub;
  logic             load, is_last;

  assign load    = q_not_empty && (!out_valid || out_ready);
  assign is_last = ({1'b0, sub} == (head.cnt - CNT_W'(1)));
  assign pop     = load && is_last;

  // Record index within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
    end else if (load) begin
      sub <= is_last ? '0 : sub + SUB_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec  <= head.recs[sub];
      out_last <= is_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/shell_line_tokenizer_unit.sv
// Top level of the shell line tokenizer: front end, bundle queue and record serializer.
`default_nettype none

// Shell line tokenizer. Takes one command-line byte per word on the slave stream, with
// s_tlast on the final byte of the line, and sends lexical records on the master stream:
// word bytes, word ends (with a truncated flag when a word passed 2047 bytes), operator
// tokens (; | & > < || && >>) and one line-end record per line; m_tlast marks the last
// record caused by an input byte. A byte is taken every cycle while the four-entry bundle
// queue has room; the front end lexes it in that same cycle. The master side sends one
// record per cycle while m_tready is high, so a byte that causes k records (k is 0 to 4)
// sends them one after another, and input stalls only once the queue has filled behind
// the output. Records pass through a queue entry and then the output register. After 256
// tokens the rest of the line yields only the line-end record.
module shell_line_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // line_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] byte_value, [10:8] op_code,
                                      // [18:11] token_number, [19] truncated, [23:20] zero
  output logic [1:0]       m_tuser,   // rec_kind
  output logic             m_tlast    // last_result
);
  import slt_pkg::*;

  logic    q_full, q_push, q_pop, q_not_empty;
  bundle_t q_in, q_head;
  rec_t    out_rec;

  slt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .line_last (s_tlast),
    .q_full    (q_full),
    .push      (q_push),
    .bundle    (q_in)
  );

  slt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  slt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_rec     (out_rec),
    .out_last    (m_tlast)
  );

  // Pack the output word
  assign m_tdata = {4'd0, out_rec.truncated, out_rec.token_number, out_rec.op_code,
                    out_rec.byte_value};
  assign m_tuser = out_rec.kind;

endmodule

`default_nettype wire
